/* src/hawkeye_cache_replacement_assert.svh */
// ----------------------------------------------------------------------------
// Hawkeye replacement assertion macros
// Shared concurrent assertion forms for the replacement block checkers.
// ----------------------------------------------------------------------------
`ifndef HAWKEYE_CACHE_REPLACEMENT_ASSERT_SVH
`define HAWKEYE_CACHE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication.
`define HCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hcr_pkg.sv */
// ----------------------------------------------------------------------------
// hcr_pkg
// Item types, operation codes and defaults for the Hawkeye replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcr_pkg;

  localparam int NUM_SETS_DEF      = 64;
  localparam int WAYS_DEF          = 16;
  localparam int HISTORY_DEPTH_DEF = 128;

  localparam logic [1:0] OP_TOUCH  = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_INVAL  = 2'd2;
  localparam logic [1:0] OP_VICTIM = 2'd3;

  localparam logic [2:0] PRIO_MAX       = 3'd7;
  localparam logic [2:0] PRIO_AGE_LIMIT = 3'd6;
  localparam logic [2:0] PRIO_FRIENDLY  = 3'd0;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] set_index;
    logic [3:0] way;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       friendly;
  } rsp_t;

endpackage

`default_nettype wire

/* src/hcr_ram.sv */
// ----------------------------------------------------------------------------
// hcr_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcr_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/hawkeye_cache_replacement.sv */
// Touch and victim items take a variable time: a touch walks the occupancy RAM port
// serially, and a victim scans the ways of the set one by one.
// A set index at or above NUM_SETS is reduced by repeated subtraction of NUM_SETS.
// One item is in flight at a time; a finished result may wait while the next is taken.
// After reset a clearing pass zeroes the per-set rows.
// ----------------------------------------------------------------------------
// hawkeye_cache_replacement
// Per-set Hawkeye replacement policy with an OPTgen occupancy history ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hawkeye_cache_replacement #(
  parameter int NUM_SETS      = hcr_pkg::NUM_SETS_DEF,
  parameter int WAYS          = hcr_pkg::WAYS_DEF,
  parameter int HISTORY_DEPTH = hcr_pkg::HISTORY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  hcr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output hcr_pkg::rsp_t rsp
);
  import hcr_pkg::*;

  localparam int PW        = $clog2(HISTORY_DEPTH);
  localparam int SW        = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WW        = $clog2(WAYS);
  localparam int CW        = $clog2(WAYS + 1);
  localparam int OFF_KNOWN = PW;
  localparam int OFF_VALID = PW + WAYS;
  localparam int OFF_PRIO  = PW + 2 * WAYS;
  localparam int OFF_LPOS  = PW + 5 * WAYS;
  localparam int ROW_W     = PW + WAYS * (5 + PW);
  localparam int OCC_DEPTH = NUM_SETS * (2 ** PW);

  localparam logic [PW-1:0] LAST_POS  = PW'(HISTORY_DEPTH - 1);
  localparam logic [SW-1:0] LAST_SET  = SW'(NUM_SETS - 1);
  localparam logic [WW-1:0] LAST_WAY  = WW'(WAYS - 1);
  localparam logic [CW-1:0] COUNT_SAT = CW'(WAYS);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_REDUCE   = 11'b000_0000_0100,
    ST_ROW_RD   = 11'b000_0000_1000,
    ST_ROW_WAIT = 11'b000_0001_0000,
    ST_DISPATCH = 11'b000_0010_0000,
    ST_WALK     = 11'b000_0100_0000,
    ST_ADV      = 11'b000_1000_0000,
    ST_RAISE    = 11'b001_0000_0000,
    ST_VSCAN    = 11'b010_0000_0000,
    ST_FINISH   = 11'b100_0000_0000
  } state_t;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] v);
    return (v == LAST_POS) ? '0 : v + 1'b1;
  endfunction

  state_t state;
  logic [1:0]    op;
  logic [5:0]    setr;
  logic [3:0]    wayr;
  logic [SW-1:0] clr;
  logic [ROW_W-1:0] row;
  logic          row_wr;
  logic [PW-1:0] p;
  logic [PW-1:0] stop;
  logic [PW-1:0] wp;
  logic          rd_pend;
  logic          fr;
  logic [WW-1:0] vi;
  logic [WW-1:0] best;
  logic [2:0]    best_pri;
  logic [3:0]    res_victim;

  logic [SW-1:0]    sa;
  logic [WW-1:0]    wi;
  logic             in_range;
  logic [PW-1:0]    ring_f;
  logic             known_w;
  logic [PW-1:0]    lpos_w;
  logic [PW-1:0]    cur_c;
  logic [2:0]       vpr;
  logic             vvld;
  logic [WW-1:0]    best_c;
  logic [2:0]       best_pri_c;
  logic [3*WAYS-1:0] aged;
  logic             out_free;
  logic             hit;

  logic             row_we;
  logic [SW-1:0]    row_waddr;
  logic [ROW_W-1:0] row_wdata;
  logic             row_re;
  logic [ROW_W-1:0] row_rdata;

  logic                occ_we;
  logic [SW+PW-1:0]    occ_waddr;
  logic [CW-1:0]       occ_wdata;
  logic                occ_re;
  logic [SW+PW-1:0]    occ_raddr;
  logic [CW-1:0]       occ_q;

  // Every occupancy slot that is read was cleared when the ring last advanced
  // into it, so the occupancy RAM needs no clearing pass.
  hcr_ram #(.DEPTH(OCC_DEPTH), .AW(SW + PW), .DW(CW)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .re(occ_re), .raddr(occ_raddr), .rdata(occ_q)
  );

  hcr_ram #(.DEPTH(NUM_SETS), .AW(SW), .DW(ROW_W)) u_row (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(row_re), .raddr(sa), .rdata(row_rdata)
  );

  assign sa       = SW'(setr);
  assign wi       = wayr[WW-1:0];
  assign in_range = {1'b0, wayr} < 5'(WAYS);
  assign ring_f   = row[PW-1:0];
  assign known_w  = row[OFF_KNOWN + int'(wi)];
  assign lpos_w   = row[OFF_LPOS + int'(wi) * PW +: PW];
  assign cur_c    = ring_next(ring_f);
  assign vpr      = row[OFF_PRIO + int'(vi) * 3 +: 3];
  assign vvld     = row[OFF_VALID + int'(vi)];
  assign out_free = !rsp_valid || rsp_ready;
  assign hit      = rd_pend && (occ_q >= COUNT_SAT);
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      aged[i*3 +: 3] = (row[OFF_PRIO + i*3 +: 3] < PRIO_AGE_LIMIT) ?
                       row[OFF_PRIO + i*3 +: 3] + 3'd1 : row[OFF_PRIO + i*3 +: 3];
    end
  end

  always_comb begin
    best_c     = best;
    best_pri_c = best_pri;
    if (!vvld) begin
      best_c = vi;
    end else if ((best_pri < vpr) || (vpr == PRIO_MAX)) begin
      best_c     = vi;
      best_pri_c = vpr;
    end
  end

  always_comb begin
    row_re    = (state == ST_ROW_RD);
    row_we    = 1'b0;
    row_waddr = sa;
    row_wdata = row;
    if (state == ST_CLEAR) begin
      row_we    = 1'b1;
      row_waddr = clr;
      row_wdata = '0;
    end else if (state == ST_FINISH) begin
      row_we = out_free && row_wr;
    end
  end

  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = {sa, wp};
    occ_wdata = (occ_q >= COUNT_SAT) ? COUNT_SAT : occ_q + 1'b1;
    occ_re    = 1'b0;
    occ_raddr = {sa, p};
    unique case (state)
      ST_WALK: begin
        occ_re = !hit && (p != stop);
      end
      ST_ADV: begin
        occ_we    = 1'b1;
        occ_waddr = {sa, cur_c};
        occ_wdata = '0;
      end
      ST_RAISE: begin
        occ_we = rd_pend;
        occ_re = (p != stop);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
      row_wr    <= 1'b0;
    end else begin
      if (rsp_ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == LAST_SET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op    <= req.operation;
            setr  <= req.set_index;
            wayr  <= req.way;
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (32'(setr) >= NUM_SETS) begin
            setr <= setr - 6'(NUM_SETS);
          end else begin
            state <= ST_ROW_RD;
          end
        end
        ST_ROW_RD: begin
          state <= ST_ROW_WAIT;
        end
        ST_ROW_WAIT: begin
          row   <= row_rdata;
          state <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          fr         <= 1'b0;
          res_victim <= '0;
          row_wr     <= 1'b0;
          rd_pend    <= 1'b0;
          if (op == OP_VICTIM) begin
            vi       <= '0;
            best     <= '0;
            best_pri <= row[OFF_PRIO +: 3];
            state    <= ST_VSCAN;
          end else if (!in_range) begin
            state <= ST_FINISH;
          end else begin
            unique case (op)
              OP_TOUCH: begin
                p    <= lpos_w;
                stop <= cur_c;
                state <= known_w ? ST_WALK : ST_ADV;
              end
              OP_FILL: begin
                state <= ST_ADV;
              end
              default: begin
                row[OFF_KNOWN + int'(wi)] <= 1'b0;
                row[OFF_VALID + int'(wi)] <= 1'b0;
                row_wr <= 1'b1;
                state  <= ST_FINISH;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (hit) begin
            fr    <= 1'b0;
            state <= ST_ADV;
          end else if (p == stop) begin
            fr    <= 1'b1;
            state <= ST_ADV;
          end else begin
            p       <= ring_next(p);
            rd_pend <= 1'b1;
          end
        end
        ST_ADV: begin
          rd_pend <= 1'b0;
          p       <= lpos_w;
          stop    <= cur_c;
          row[PW-1:0]                          <= cur_c;
          row[OFF_LPOS + int'(wi) * PW +: PW]  <= cur_c;
          row[OFF_KNOWN + int'(wi)]            <= 1'b1;
          row[OFF_PRIO + int'(wi) * 3 +: 3]    <=
            (op == OP_TOUCH && fr) ? PRIO_FRIENDLY : PRIO_MAX;
          if (op == OP_FILL) begin
            row[OFF_VALID + int'(wi)] <= 1'b1;
          end
          row_wr <= 1'b1;
          state  <= (op == OP_TOUCH && fr && known_w) ? ST_RAISE : ST_FINISH;
        end
        ST_RAISE: begin
          if (p != stop) begin
            wp      <= p;
            p       <= ring_next(p);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_VSCAN: begin
          best     <= best_c;
          best_pri <= best_pri_c;
          vi       <= vi + 1'b1;
          if (!vvld || vi == LAST_WAY) begin
            res_victim <= 4'(best_c);
            row[OFF_PRIO +: 3*WAYS] <= aged;
            row_wr <= 1'b1;
            state  <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            rsp_valid       <= 1'b1;
            rsp.victim_way  <= res_victim;
            rsp.friendly    <= fr;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/hcr_checker.sv */
// ----------------------------------------------------------------------------
// hcr_checker
// Port-level checks for the Hawkeye replacement block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hawkeye_cache_replacement_assert.svh"

module hcr_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire hcr_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire hcr_pkg::rsp_t rsp
);

  `HCR_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")
  `HCR_ASSERT_NXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp), "stalled result item changed")
  `HCR_ASSERT_NXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "second item taken while one is in work")
  `HCR_ASSERT_IMP(a_exclusive_fields, clk, rst, rsp_valid && rsp.friendly, rsp.victim_way == 4'd0, "friendly touch carries a victim way")

endmodule

bind hawkeye_cache_replacement hcr_checker u_hcr_checker (.*);

`default_nettype wire

/* tb/sv/hawkeye_cache_replacement_tb.sv */
// ----------------------------------------------------------------------------
// Hawkeye replacement testbench
// Drives touch, fill, invalidate and victim items into the replacement block
// and checks every response against a cycle-free model of the policy state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class hcr_scoreboard;
  localparam int NS = 64;
  localparam int NW = 16;
  localparam int HD = 128;

  logic [4:0] occ[NS][HD];
  logic [6:0] ring_pos[NS];
  logic [6:0] last_pos[NS][NW];
  bit         pos_known[NS][NW];
  logic [2:0] prio[NS][NW];
  bit         valid_line[NS][NW];
  hcr_pkg::rsp_t pending[$];
  int errors;

  function new();
    errors = 0;
    for (int s = 0; s < NS; s++) begin
      ring_pos[s] = '0;
      for (int p = 0; p < HD; p++) occ[s][p] = '0;
      for (int w = 0; w < NW; w++) begin
        last_pos[s][w] = '0;
        pos_known[s][w] = 0;
        prio[s][w] = '0;
        valid_line[s][w] = 0;
      end
    end
  endfunction

  function bit is_friendly(int s, int w);
    int p;
    int stop;
    if (!pos_known[s][w]) return 0;
    p = last_pos[s][w];
    stop = (ring_pos[s] + 1) % HD;
    for (int n = 0; n < HD && p != stop; n++) begin
      if (occ[s][p] >= NW) return 0;
      p = (p + 1) % HD;
    end
    return 1;
  endfunction

  function void advance_ring(int s, int w, bit raise);
    int cur;
    int p;
    cur = (ring_pos[s] + 1) % HD;
    ring_pos[s] = cur[6:0];
    occ[s][cur] = '0;
    if (raise && pos_known[s][w]) begin
      p = last_pos[s][w];
      for (int n = 0; n < HD && p != cur; n++) begin
        if (occ[s][p] < NW) occ[s][p] = occ[s][p] + 1'b1;
        p = (p + 1) % HD;
      end
    end
    last_pos[s][w] = cur[6:0];
    pos_known[s][w] = 1;
  endfunction

  function void note_request(hcr_pkg::req_t r);
    hcr_pkg::rsp_t e;
    int s;
    int w;
    int best;
    int best_pri;
    e = '0;
    s = r.set_index % NS;
    w = r.way;
    if (r.operation == hcr_pkg::OP_VICTIM) begin
      best = 0;
      best_pri = prio[s][0];
      for (int i = 0; i < NW; i++) begin
        if (!valid_line[s][i]) begin
          best = i;
          break;
        end
        if (best_pri < prio[s][i] || prio[s][i] == hcr_pkg::PRIO_MAX) begin
          best = i;
          best_pri = prio[s][i];
        end
      end
      e.victim_way = best[3:0];
      for (int i = 0; i < NW; i++)
        if (prio[s][i] < hcr_pkg::PRIO_AGE_LIMIT) prio[s][i] = prio[s][i] + 1'b1;
    end else if (w < NW) begin
      if (r.operation == hcr_pkg::OP_TOUCH) begin
        e.friendly = is_friendly(s, w);
        prio[s][w] = e.friendly ? hcr_pkg::PRIO_FRIENDLY : hcr_pkg::PRIO_MAX;
        advance_ring(s, w, e.friendly);
      end else if (r.operation == hcr_pkg::OP_FILL) begin
        pos_known[s][w] = 0;
        advance_ring(s, w, 0);
        prio[s][w] = hcr_pkg::PRIO_MAX;
        valid_line[s][w] = 1;
      end else begin
        pos_known[s][w] = 0;
        valid_line[s][w] = 0;
      end
    end
    pending.push_back(e);
  endfunction

  function void check_response(hcr_pkg::rsp_t got);
    hcr_pkg::rsp_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected response: victim %0d friendly %0d",
                                 got.victim_way, got.friendly);
      return;
    end
    e = pending.pop_front();
    if (got.victim_way !== e.victim_way || got.friendly !== e.friendly) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch: expected victim %0d friendly %0d, got victim %0d friendly %0d",
                 e.victim_way, e.friendly, got.victim_way, got.friendly);
    end
  endfunction
endclass

module hawkeye_cache_replacement_tb;
  import hcr_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;

  hcr_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;
  bit stim_done;

  hawkeye_cache_replacement uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic idle_cycle();
    req_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_item(input req_t r);
    while ($urandom_range(99) < send_idle_pct) idle_cycle();
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  function automatic req_t make_req(logic [1:0] op, int s, int w);
    req_t r;
    r.operation = op;
    r.set_index = s[5:0];
    r.way = w[3:0];
    return r;
  endfunction

  // Mostly well-formed traffic on a few hot sets so rings wrap and counters saturate.
  function automatic req_t random_req();
    int k;
    int s;
    k = $urandom_range(99);
    s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
    if (k < 55) return make_req(OP_TOUCH, s, $urandom_range(15));
    if (k < 70) return make_req(OP_FILL, s, $urandom_range(15));
    if (k < 78) return make_req(OP_INVAL, s, $urandom_range(15));
    if (k < 97) return make_req(OP_VICTIM, s, $urandom_range(15));
    return make_req(2'($urandom_range(3)), $urandom_range(63), $urandom_range(15));
  endfunction

  task automatic wait_drained();
    do idle_cycle(); while (sb.pending.size() != 0);
  endtask

  initial begin
    int limit;
    sb = new();
    cycles = 0;
    send_idle_pct = 11;
    recv_idle_pct = 81;
    repeat (8) @(posedge clk);
    rst <= 0;
    for (int w = 0; w < 16; w++) send_item(make_req(OP_FILL, 0, w));
    send_item(make_req(OP_VICTIM, 0, 0));
    send_item(make_req(OP_TOUCH, 0, 15));
    send_item(make_req(OP_TOUCH, 0, 15));
    send_item(make_req(OP_TOUCH, 63, 3));
    send_item(make_req(OP_INVAL, 0, 4));
    send_item(make_req(OP_VICTIM, 0, 15));
    send_item(make_req(OP_VICTIM, 63, 0));
    send_item(make_req(OP_TOUCH, 0, 0));
    wait_drained();
    for (int i = 0; i < 1550; i++) begin
      if (i == 520) begin
        send_idle_pct = 81;
        recv_idle_pct = 11;
      end
      if (i == 1040) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 700) wait_drained();
      send_item(random_req());
    end
    req_valid <= 0;
    limit = 0;
    while (sb.pending.size() != 0 && limit < 200000) begin
      @(posedge clk);
      limit++;
    end
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* files.f */
+incdir+src
src/hcr_pkg.sv
src/hcr_ram.sv
src/hawkeye_cache_replacement.sv
src/hcr_checker.sv
tb/sv/hawkeye_cache_replacement_tb.sv
